>>> hw/rtl/ptmg_pkg.sv
// ----------------------------------------------------------------------------
// ptmg_pkg
// Shared types and constants for the pulse train merge generator.
// ----------------------------------------------------------------------------
package ptmg_pkg;

    // Default depth of the segment list.
    localparam int MAX_SEGMENTS_DEF = 32;

    // Action codes of an input word.
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_PULSE  = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NEG_START = 2'd1,
        ST_NEG_WIDTH = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Operation kinds after classification.
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_PULSE  = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RD,
        S_PROC,
        S_EMIT,
        S_END,
        S_DONE,
        S_RESP
    } t_state;

    // Input word.
    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] segment_value;
        logic signed [31:0] pulse_start;
        logic signed [31:0] pulse_width;
    } t_in;

    // Result word.
    typedef struct packed {
        logic        level;
        logic [1:0]  status;
        logic [5:0]  segment_count;
        logic [31:0] tick_total;
    } t_res;

    // Classified operation held in the queue.
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic signed [31:0] value;
        logic signed [31:0] pstart;
        logic signed [31:0] pwidth;
    } t_op;

endpackage

>>> hw/rtl/ptmg_front.sv
// ----------------------------------------------------------------------------
// ptmg_front
// Accepts input words, checks their arguments and turns them into operations.
// ----------------------------------------------------------------------------
module ptmg_front
    import ptmg_pkg::*;
(
    input  logic i_start,
    input  t_in  i_item,
    input  logic i_full,
    output logic o_busy,
    output logic o_push,
    output t_op  o_op
);

    // The front end stalls only when the queue is full.
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // Classify the word and settle argument errors early.
    always_comb begin
        o_op.kind   = KIND_REPORT;
        o_op.status = ST_OK;
        o_op.value  = i_item.segment_value;
        o_op.pstart = i_item.pulse_start;
        o_op.pwidth = i_item.pulse_width;
        unique case (i_item.action)
            ACT_APPEND: begin
                // The most negative value saturates; zero is ignored.
                if (i_item.segment_value == 32'sh8000_0000) begin
                    o_op.value = -32'sd2147483647;
                end
                if (i_item.segment_value != '0) begin
                    o_op.kind = KIND_APPEND;
                end
            end
            ACT_PULSE: begin
                if (i_item.pulse_width[31]) begin
                    o_op.status = ST_NEG_WIDTH;
                end else if (i_item.pulse_start[31]) begin
                    o_op.status = ST_NEG_START;
                end else if (i_item.pulse_width != '0) begin
                    o_op.kind = KIND_PULSE;
                end
            end
            ACT_TICK: begin
                o_op.kind = KIND_TICK;
            end
            default: begin
                o_op.kind = KIND_REPORT;
            end
        endcase
    end

endmodule

>>> hw/rtl/ptmg_queue.sv
// ----------------------------------------------------------------------------
// ptmg_queue
// Two-entry queue of operations between the front and back ends.
// ----------------------------------------------------------------------------
module ptmg_queue
    import ptmg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_op  o_op
);

    t_op        r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_op    = r_buf[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_op;
        end
    end

endmodule

>>> hw/rtl/ptmg_back.sv
// ----------------------------------------------------------------------------
// ptmg_back
// Executes operations on the segment list and issues one result per word.
// ----------------------------------------------------------------------------
module ptmg_back
    import ptmg_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_op  i_op,
    output logic o_pop,
    output logic o_strobe,
    output t_res o_result
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = $clog2(2 * MAX_SEGMENTS);
    localparam int SW = 34;

    // Two banks: the live list and the scratch list of a merge.
    logic signed [31:0] mem [0:2*MAX_SEGMENTS-1];
    logic signed [31:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_wdata;

    t_state             r_state, n_state;
    logic               r_bank, n_bank;
    logic [IW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_head_val, n_head_val;
    logic [31:0]        r_ticks, n_ticks;
    t_status            r_status, n_status;
    t_op                r_op, n_op;
    logic signed [SW-1:0] r_start, n_start;
    logic signed [SW-1:0] r_width, n_width;
    logic [CW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_rp, n_rp;
    logic [CW-1:0]      r_wcnt, n_wcnt;
    logic               r_ovf, n_ovf;
    logic signed [31:0] r_first, n_first;
    logic signed [31:0] r_e [3];
    logic signed [31:0] n_e [3];
    logic [1:0]         r_ne, n_ne;
    logic [1:0]         r_k, n_k;
    logic               r_last, n_last;
    logic               r_strobe, n_strobe;
    t_res               r_res, n_res;

    // Merge datapath signals.
    logic signed [SW-1:0] d, dur, delay;
    logic [CW:0]          tail_sum;
    logic [IW-1:0]        tail;
    logic signed [31:0]   tick_val;

    function automatic logic [AW-1:0] addr_of(input logic bank, input logic [IW-1:0] idx);
        addr_of = bank ? AW'(MAX_SEGMENTS) + AW'(idx) : AW'(idx);
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        wrap_inc = (p == IW'(MAX_SEGMENTS - 1)) ? '0 : p + IW'(1);
    endfunction

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // Memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Tail position of the live list, next head value of a tick and merge delay.
    always_comb begin
        tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
        if (tail_sum >= (CW+1)'(MAX_SEGMENTS)) begin
            tail = IW'(tail_sum - (CW+1)'(MAX_SEGMENTS));
        end else begin
            tail = IW'(tail_sum);
        end
        tick_val = r_head_val[31] ? r_head_val + 32'sd1 : r_head_val - 32'sd1;
        d     = SW'(r_rdata);
        dur   = d[SW-1] ? -d : d;
        delay = r_start - dur;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_head     = r_head;
        n_count    = r_count;
        n_head_val = r_head_val;
        n_ticks    = r_ticks;
        n_status   = r_status;
        n_op       = r_op;
        n_start    = r_start;
        n_width    = r_width;
        n_idx      = r_idx;
        n_rp       = r_rp;
        n_wcnt     = r_wcnt;
        n_ovf      = r_ovf;
        n_first    = r_first;
        n_e        = r_e;
        n_ne       = r_ne;
        n_k        = r_k;
        n_last     = r_last;
        n_strobe   = 1'b0;
        n_res      = r_res;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = addr_of(r_bank, tail);
        mem_wdata  = r_op.value;
        mem_raddr  = addr_of(r_bank, r_rp);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_op;
                    n_status = i_op.status;
                    n_state  = S_RESP;
                    unique case (i_op.kind)
                        KIND_APPEND: begin
                            if (r_count == CW'(MAX_SEGMENTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_of(r_bank, tail);
                                mem_wdata = i_op.value;
                                n_count   = r_count + CW'(1);
                                if (r_count == '0) begin
                                    n_head_val = i_op.value;
                                end
                            end
                        end
                        KIND_TICK: begin
                            n_ticks = r_ticks + 32'd1;
                            if (r_count != '0) begin
                                if (tick_val == '0) begin
                                    // Head segment is used up: drop it.
                                    n_head    = wrap_inc(r_head);
                                    n_count   = r_count - CW'(1);
                                    mem_raddr = addr_of(r_bank, wrap_inc(r_head));
                                    if (r_count != CW'(1)) begin
                                        n_state = S_LOAD;
                                    end
                                end else begin
                                    n_head_val = tick_val;
                                    mem_we     = 1'b1;
                                    mem_waddr  = addr_of(r_bank, r_head);
                                    mem_wdata  = tick_val;
                                end
                            end
                        end
                        KIND_PULSE: begin
                            n_start = SW'(i_op.pstart);
                            n_width = SW'(i_op.pwidth);
                            n_idx   = '0;
                            n_rp    = r_head;
                            n_wcnt  = '0;
                            n_ovf   = 1'b0;
                            n_state = S_RD;
                        end
                        KIND_REPORT: begin
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_head_val = r_rdata;
                n_state    = S_RESP;
            end
            S_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_END;
                end else begin
                    mem_raddr = addr_of(r_bank, r_rp);
                    n_state   = S_PROC;
                end
            end
            S_PROC: begin
                // One stored segment against the pending pulse.
                n_rp   = wrap_inc(r_rp);
                n_idx  = r_idx + CW'(1);
                n_k    = '0;
                n_last = 1'b0;
                n_ne   = 2'd1;
                n_e[0] = r_rdata;
                priority if (r_width <= 0) begin
                    n_e[0] = r_rdata;
                end else if (delay >= 0 || d == 0) begin
                    n_start = delay;
                end else if (d > 0) begin
                    n_width = r_width + delay;
                    n_start = '0;
                end else if (r_start == 0 && r_width < dur) begin
                    n_e[0]  = 32'(r_width);
                    n_e[1]  = 32'(r_width - dur);
                    n_ne    = 2'd2;
                    n_width = '0;
                end else if (r_start == 0) begin
                    n_e[0]  = 32'(dur);
                    n_width = r_width - dur;
                end else if (r_width < -delay) begin
                    n_e[0]  = 32'(-r_start);
                    n_e[1]  = 32'(r_width);
                    n_e[2]  = 32'(delay + r_width);
                    n_ne    = 2'd3;
                    n_width = '0;
                end else begin
                    n_e[0]  = 32'(-r_start);
                    n_e[1]  = 32'(dur - r_start);
                    n_ne    = 2'd2;
                    n_width = r_width - (dur - r_start);
                    n_start = '0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Write one piece of the merged list into the scratch bank.
                if (r_wcnt == CW'(MAX_SEGMENTS)) begin
                    n_ovf = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(!r_bank, IW'(r_wcnt));
                    mem_wdata = r_e[r_k];
                    n_wcnt    = r_wcnt + CW'(1);
                    if (r_wcnt == '0) begin
                        n_first = r_e[r_k];
                    end
                end
                if (r_k == r_ne - 2'd1) begin
                    n_state = r_last ? S_DONE : S_RD;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_END: begin
                // Pulse reaches past the list: pad with low time when it starts later, then high.
                if (r_width > 0) begin
                    n_k    = '0;
                    n_last = 1'b1;
                    if (r_start > 0) begin
                        n_e[0] = 32'(-r_start);
                        n_e[1] = 32'(r_width);
                        n_ne   = 2'd2;
                    end else begin
                        n_e[0] = 32'(r_width);
                        n_ne   = 2'd1;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_ovf) begin
                    n_status = ST_FULL;
                end else begin
                    n_bank     = !r_bank;
                    n_head     = '0;
                    n_count    = r_wcnt;
                    n_head_val = r_first;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                n_strobe              = 1'b1;
                n_res.level           = (r_count != '0) && !r_head_val[31] &&
                                        (r_head_val != '0);
                n_res.status          = r_status;
                n_res.segment_count   = 6'(r_count);
                n_res.tick_total      = r_ticks;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bank   <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_ticks  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ticks  <= n_ticks;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_head_val <= n_head_val;
        r_status   <= n_status;
        r_op       <= n_op;
        r_start    <= n_start;
        r_width    <= n_width;
        r_idx      <= n_idx;
        r_rp       <= n_rp;
        r_wcnt     <= n_wcnt;
        r_ovf      <= n_ovf;
        r_first    <= n_first;
        r_e        <= n_e;
        r_ne       <= n_ne;
        r_k        <= n_k;
        r_last     <= n_last;
        r_res      <= n_res;
    end

endmodule

>>> hw/rtl/pulse_train_merge_generator.sv
// ----------------------------------------------------------------------------
// pulse_train_merge_generator
// Segment list pulse generator with append, pulse merge and tick commands.
// ----------------------------------------------------------------------------
// Words are taken whenever busy is low and queue up to two deep; busy rises
// only while both queue entries are taken. Each word yields one result, shown
// for one cycle with o_strobe, which the receiver must take at once. Append,
// tick and report words pass from the idle state to the response state, a
// tick that drops the head by way of a load state. A pulse merge walks the
// stored list through the single read port of the memory: a read and a process
// state per stored segment and an emit state per written piece. The merged
// list holds at most two pieces more than the stored one.
// ----------------------------------------------------------------------------
module pulse_train_merge_generator
    import ptmg_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_res o_result
);

    logic q_push, q_full, q_valid, q_pop;
    t_op  f_op, q_op;

    // Front end: accept and classify.
    ptmg_front u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_op    (f_op)
    );

    // Queue between the two ends.
    ptmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_op    (q_op)
    );

    // Back end: list operations and results.
    ptmg_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_op     (q_op),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

>>> hw/rtl/ptmg_checker.sv
// ----------------------------------------------------------------------------
// ptmg_checker
// Port-level checks of the pulse train merge generator.
// ----------------------------------------------------------------------------
module ptmg_checker
    import ptmg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // No result and no stall right after reset.
    a_rst_strobe: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // Results never come in two adjacent cycles.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results in adjacent cycles");

    // Busy rises only after a word was accepted.
    a_busy_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !(start && !busy) |=> !busy)
        else $error("busy rose without an accepted word");

endmodule

bind pulse_train_merge_generator ptmg_checker u_ptmg_checker (.*);

>>> verif/tb_pulse_train_merge_generator.sv
// ----------------------------------------------------------------------------
// tb_pulse_train_merge_generator
// Self-checking testbench for the pulse train merge generator.
// ----------------------------------------------------------------------------
// An initial block queues directed and random command words. A clocked driver
// offers them with random gaps. An in-bench segment list model predicts one
// result word per accepted command. A clocked monitor compares each strobed
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pulse_train_merge_generator;
    import ptmg_pkg::*;

    localparam int SEG_MAX    = MAX_SEGMENTS_DEF;
    localparam int WORK_MAX   = SEG_MAX + 2;
    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct {
        t_in cmd;
        bit  drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_strobe;
    t_res o_result;

    t_pending cmd_queue[$];
    t_res     expected_results[$];
    int       error_count = 0;
    int       accepted_count = 0;
    int       cycle_count = 0;

    // Shadow copy of the segment list.
    longint   seg_list[SEG_MAX];
    int       seg_total = 0;
    logic [31:0] tick_sum = '0;

    pulse_train_merge_generator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Inserts into the merge work list; returns 0 when there is no room or the position lies past the end.
    function automatic bit work_put(ref longint w[WORK_MAX], ref int n, input int pos,
                                    input longint v);
        if (n >= WORK_MAX || pos > n) return 1'b0;
        for (int k = n; k > pos; k--) w[k] = w[k - 1];
        w[pos] = v;
        n++;
        return 1'b1;
    endfunction

    // Merges a high pulse into the list and returns the status.
    function automatic t_status merge_pulse(input longint pstart, input longint pwidth);
        longint w[WORK_MAX];
        int     n;
        int     idx;
        bit     ok;
        longint d, dur, delay;
        n = seg_total;
        idx = 0;
        ok = 1'b1;
        if (pwidth < 0) return ST_NEG_WIDTH;
        if (pstart < 0) return ST_NEG_START;
        for (int k = 0; k < n; k++) w[k] = seg_list[k];
        while (pwidth > 0 && ok) begin
            if (idx >= n) begin
                if (pstart > 0) ok = work_put(w, n, n, -pstart);
                if (ok) ok = work_put(w, n, n, pwidth);
                break;
            end
            d = w[idx];
            dur = (d < 0) ? -d : d;
            delay = pstart - dur;
            if (delay >= 0 || d == 0) begin
                pstart -= dur;
                idx++;
                continue;
            end
            if (d > 0) begin
                pwidth += delay;
                pstart = 0;
                idx++;
                continue;
            end
            if (pstart == 0 && pwidth < dur) begin
                w[idx] = pwidth;
                ok = work_put(w, n, idx + 1, pwidth - dur);
                break;
            end
            if (pstart == 0) begin
                w[idx] = dur;
                pwidth -= dur;
                idx++;
                continue;
            end
            if (pwidth < -delay) begin
                w[idx] = -pstart;
                ok = work_put(w, n, idx + 1, pwidth);
                if (ok) ok = work_put(w, n, idx + 2, delay + pwidth);
                break;
            end
            w[idx] = -pstart;
            ok = work_put(w, n, idx + 1, dur - pstart);
            pwidth -= dur - pstart;
            idx += 2;
            pstart = 0;
        end
        if (!ok || n > SEG_MAX) return ST_FULL;
        for (int k = 0; k < n; k++) seg_list[k] = w[k];
        seg_total = n;
        return ST_OK;
    endfunction

    // Applies one command word to the shadow list and queues its result.
    function automatic void apply_command(input t_in cmd);
        t_res    r;
        t_status st;
        longint  v;
        st = ST_OK;
        case (cmd.action)
            ACT_APPEND: begin
                v = cmd.segment_value;
                if (v < -64'sd2147483647) v = -64'sd2147483647;
                if (v != 0) begin
                    if (seg_total >= SEG_MAX) st = ST_FULL;
                    else begin
                        seg_list[seg_total] = v;
                        seg_total++;
                    end
                end
            end
            ACT_PULSE: st = merge_pulse(longint'(cmd.pulse_start), longint'(cmd.pulse_width));
            ACT_TICK: begin
                tick_sum++;
                if (seg_total > 0) begin
                    v = (seg_list[0] > 0) ? seg_list[0] - 1 : seg_list[0] + 1;
                    if (v == 0) begin
                        for (int k = 0; k < seg_total - 1; k++) seg_list[k] = seg_list[k + 1];
                        seg_total--;
                    end else begin
                        seg_list[0] = v;
                    end
                end
            end
            default: ;
        endcase
        r.level = (seg_total > 0 && seg_list[0] > 0);
        r.status = st;
        r.segment_count = 6'(seg_total);
        r.tick_total = tick_sum;
        expected_results.push_back(r);
    endfunction

    function automatic void queue_cmd(input logic [1:0] act, input logic [31:0] sv,
                                      input logic [31:0] ps, input logic [31:0] pw,
                                      input bit drain = 1'b0);
        t_pending p;
        p.cmd.action = act;
        p.cmd.segment_value = sv;
        p.cmd.pulse_start = ps;
        p.cmd.pulse_width = pw;
        p.drain = drain;
        cmd_queue.push_back(p);
    endfunction

    // Random command: mostly small durations so merges and pops stay lively;
    // fields unused by the action carry full-range random bits.
    function automatic void queue_random(input bit drain);
        int          sel;
        logic [1:0]  act;
        logic [31:0] sv, ps, pw;
        sel = $urandom_range(99);
        sv = $urandom;
        ps = $urandom;
        pw = $urandom;
        if (sel < 30) begin
            act = ACT_APPEND;
            sv = $urandom_range(20, 1);
            if ($urandom_range(1)) sv = -sv;
            if ($urandom_range(30) == 0) sv = 0;
        end else if (sel < 62) begin
            act = ACT_PULSE;
            ps = $urandom_range(60);
            pw = $urandom_range(40);
            if ($urandom_range(15) == 0) ps = $urandom | 32'h8000_0000;
            if ($urandom_range(15) == 0) pw = $urandom | 32'h8000_0000;
        end else if (sel < 96) begin
            act = ACT_TICK;
        end else begin
            act = ACT_NOP;
        end
        queue_cmd(act, sv, ps, pw, drain);
    endfunction

    // Stimulus.
    initial begin
        // Directed: zero append, pulse cases, ticks, negatives, no-op.
        queue_cmd(ACT_TICK, 32'h0, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, 32'h0, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, 32'd5, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, -32'sd10, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, 32'd3, 32'h0, 32'h0);
        queue_cmd(ACT_PULSE, 32'h0, 32'd7, 32'd2);
        queue_cmd(ACT_PULSE, 32'h0, 32'd4, 32'd3);
        queue_cmd(ACT_PULSE, 32'h0, 32'd12, 32'd20);
        queue_cmd(ACT_PULSE, 32'h0, 32'd0, 32'd0);
        queue_cmd(ACT_PULSE, 32'h0, 32'h8000_0000, 32'd4);
        queue_cmd(ACT_PULSE, 32'h0, 32'd3, 32'h8000_0000);
        queue_cmd(ACT_PULSE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(ACT_PULSE, 32'h0, 32'd80, 32'd5);
        queue_cmd(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) queue_cmd(ACT_TICK, 32'h0, 32'h0, 32'h0);
        // Random part; one command waits for every outstanding result.
        for (int k = 0; k < N_RANDOM; k++) queue_random(k == 500);
        // Extremes last, since huge segments never drain.
        for (int k = 0; k < SEG_MAX + 1; k++) queue_cmd(ACT_APPEND, -32'sd1, 32'h0, 32'h0);
        for (int k = 0; k < 40; k++) queue_cmd(ACT_TICK, 32'h0, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_cmd(ACT_APPEND, 32'h8000_0000, 32'h0, 32'h0);
        queue_cmd(ACT_PULSE, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_cmd(ACT_PULSE, 32'h0, 32'h0, 32'h7FFF_FFFF);
        queue_cmd(ACT_TICK, 32'h0, 32'h0, 32'h0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (cmd_queue.size() == 0 && !start && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Driver: offers the next word unless idling or waiting for a drain.
    always @(posedge i_clk) begin
        bit idle;
        if (i_rst_n) begin
            if (start && !busy) begin
                apply_command(i_item);
                accepted_count++;
            end
            if (!start || !busy) begin
                idle = (accepted_count < 900 || accepted_count > 1300)
                       && ($urandom_range(99) < 18);
                if (cmd_queue.size() > 0 && !idle
                    && !(cmd_queue[0].drain && expected_results.size() > 0)) begin
                    start <= 1'b1;
                    i_item <= cmd_queue[0].cmd;
                    void'(cmd_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_result.level !== e.level || o_result.status !== e.status
                    || o_result.segment_count !== e.segment_count
                    || o_result.tick_total !== e.tick_total) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
